### hdl/page_frame_list_manager_assert.svh
// Assertion macros for the page frame list manager.
// Used by the top level only; no other dependencies.
`ifndef PAGE_FRAME_LIST_MANAGER_ASSERT_SVH
`define PAGE_FRAME_LIST_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PFLM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pflm assertion failed");
// next-cycle implication
`define PFLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pflm assertion failed");
`else
`define PFLM_ASSERT_NOW(lbl, ante, cons)
`define PFLM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/pflm_pkg.sv
// Shared constants, types and counter helpers for the page frame list manager.
// No dependencies.
package pflm_pkg;

  localparam int NUM_FRAMES  = 1024;
  localparam int NUM_BUCKETS = 16;
  localparam int NUM_LISTS   = 2 * NUM_BUCKETS + 2;
  localparam int PTR_W       = $clog2(NUM_FRAMES + 1);  // frame number or none
  localparam int IDX_W       = $clog2(NUM_FRAMES);      // link store index
  localparam int LIST_W      = $clog2(NUM_LISTS);       // list table index
  localparam int SEL_W       = 6;
  localparam int FRM_W       = 10;
  localparam int REQ_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(NUM_FRAMES);

  // request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_ADD_HEAD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_TAIL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_HEAD = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_TAIL = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd4;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_ADD_HEAD,
    OP_ADD_TAIL,
    OP_POP_HEAD,
    OP_POP_TAIL,
    OP_REMOVE,
    OP_NOP_CNT,   // report current count only
    OP_NOP_ZERO   // list out of range
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SEL_W-1:0] list;
    logic [FRM_W-1:0] frame;
  } req_t;

  // one list table row
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] size;
  } tab_t;

  function automatic logic [PTR_W-1:0] cnt_up(input logic [PTR_W-1:0] c);
    return (c >= NONE_PTR) ? NONE_PTR : c + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] cnt_down(input logic [PTR_W-1:0] c);
    return (c == '0) ? '0 : c - 1'b1;
  endfunction

endpackage

### hdl/pflm_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on pflm_pkg.
module pflm_front import pflm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [SEL_W-1:0] list_sel_i,
  input  logic [FRM_W-1:0] frame_num_i,
  output logic             q_valid_o,
  output req_t             q_req_o,
  input  logic             q_pop_i
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  req_t             fifo_q [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0]  cnt_q;
  req_t             cls;
  logic             frm_ok;
  logic             push, pop;

  // classify the incoming request
  always_comb begin
    frm_ok     = ({1'b0, frame_num_i} < NONE_PTR);
    cls.list   = list_sel_i;
    cls.frame  = frame_num_i;
    if (list_sel_i >= SEL_W'(NUM_LISTS)) begin
      cls.op = OP_NOP_ZERO;
    end else begin
      case (req_type_i)
        REQ_ADD_HEAD: cls.op = frm_ok ? OP_ADD_HEAD : OP_NOP_CNT;
        REQ_ADD_TAIL: cls.op = frm_ok ? OP_ADD_TAIL : OP_NOP_CNT;
        REQ_POP_HEAD: cls.op = OP_POP_HEAD;
        REQ_POP_TAIL: cls.op = OP_POP_TAIL;
        REQ_REMOVE:   cls.op = frm_ok ? OP_REMOVE : OP_NOP_CNT;
        default:      cls.op = OP_NOP_CNT;
      endcase
    end
  end

  assign in_ready_o = (cnt_q != QC_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_req_o    = fifo_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### hdl/pflm_back.sv
// Back end: list table, link stores and the sequencer that carries out requests.
// Depends on pflm_pkg.
module pflm_back import pflm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  req_t             q_req_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [FRM_W-1:0] out_frame_o,
  output logic             was_empty_o,
  output logic [PTR_W-1:0] list_count_o,
  output logic [PTR_W-1:0] free_total_o,
  output logic [PTR_W-1:0] zero_total_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TAB  = 2'd1;
  localparam logic [1:0] ST_LNK  = 2'd2;
  localparam logic [1:0] ST_W2   = 2'd3;

  typedef enum logic [2:0] {
    K_ADDH, K_ADDT, K_TAKEH, K_TAKET, K_MID, K_EMPTY, K_NONE, K_ZERO
  } kind_e;

  logic [1:0]           state_q, state_d;
  req_t                 req_q;
  kind_e                kind, kind_q;

  // list table and link stores
  tab_t                 tab_mem [NUM_LISTS];
  logic [NUM_LISTS-1:0] tab_vld_q;
  tab_t                 tab_rd_q;
  logic                 tab_rd_vld_q;
  tab_t                 tab_cur, tab_new;
  logic                 tab_we;
  logic [PTR_W-1:0]     nxt_mem [NUM_FRAMES];
  logic [PTR_W-1:0]     prv_mem [NUM_FRAMES];
  logic [PTR_W-1:0]     nxt_rd_q, prv_rd_q;
  logic [IDX_W-1:0]     nrd_addr, prd_addr;
  logic                 nxt_we, prv_we;
  logic [IDX_W-1:0]     nxt_wa, prv_wa;
  logic [PTR_W-1:0]     nxt_wd, prv_wd;

  logic [PTR_W-1:0]     free_q, zero_q;
  logic [FRM_W-1:0]     res_frame_q, res_frame_d;
  logic                 res_empty_q, res_empty_d;
  logic [PTR_W-1:0]     res_cnt_q;
  logic                 cnt_inc, cnt_dec;
  logic                 out_valid_q;
  logic [FRM_W-1:0]     out_frame_q;
  logic                 out_empty_q;
  logic [PTR_W-1:0]     out_cnt_q, out_free_q, out_zero_q;

  logic [PTR_W-1:0]     h, t, f11, n, p;
  logic                 h_ok, t_ok, n_ok, p_ok, empty;
  logic                 is_free, is_zero, slot_free;

  assign tab_cur = tab_rd_vld_q ? tab_rd_q : tab_t'{head: NONE_PTR, tail: NONE_PTR, size: '0};
  assign h       = tab_cur.head;
  assign t       = tab_cur.tail;
  assign f11     = {1'b0, req_q.frame};
  assign n       = nxt_rd_q;
  assign p       = prv_rd_q;
  assign h_ok    = (h < NONE_PTR);
  assign t_ok    = (t < NONE_PTR);
  assign n_ok    = (n < NONE_PTR);
  assign p_ok    = (p < NONE_PTR);
  assign empty   = !h_ok || !t_ok;
  assign is_free = (req_q.list < SEL_W'(NUM_BUCKETS));
  assign is_zero = !is_free && (req_q.list < SEL_W'(2 * NUM_BUCKETS));
  assign slot_free = !out_valid_q || out_ready_i;
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  // decide what the request does once its table row is in
  always_comb begin
    case (req_q.op)
      OP_ADD_HEAD: kind = K_ADDH;
      OP_ADD_TAIL: kind = K_ADDT;
      OP_POP_HEAD: kind = empty ? K_EMPTY : K_TAKEH;
      OP_POP_TAIL: kind = empty ? K_EMPTY : K_TAKET;
      OP_REMOVE: begin
        if (empty)           kind = K_EMPTY;
        else if (t == f11)   kind = K_TAKET;
        else if (h == f11)   kind = K_TAKEH;
        else                 kind = K_MID;
      end
      OP_NOP_ZERO: kind = K_ZERO;
      default:     kind = K_NONE;
    endcase
    nrd_addr = (kind == K_TAKEH) ? h[IDX_W-1:0] : req_q.frame[IDX_W-1:0];
    prd_addr = (kind == K_TAKET) ? t[IDX_W-1:0] : req_q.frame[IDX_W-1:0];
  end

  // table update, link writes and result once neighbour links are in
  always_comb begin
    tab_new     = tab_cur;
    tab_we      = 1'b0;
    cnt_inc     = 1'b0;
    cnt_dec     = 1'b0;
    res_frame_d = '0;
    res_empty_d = 1'b0;
    nxt_we      = 1'b0;
    prv_we      = 1'b0;
    nxt_wa      = req_q.frame[IDX_W-1:0];
    prv_wa      = req_q.frame[IDX_W-1:0];
    nxt_wd      = NONE_PTR;
    prv_wd      = NONE_PTR;
    case (kind_q)
      K_ADDH: begin
        tab_we = 1'b1; cnt_inc = 1'b1;
        tab_new.head = f11;
        if (!h_ok) tab_new.tail = f11;
        nxt_we = 1'b1; nxt_wd = h;
        prv_we = 1'b1;
      end
      K_ADDT: begin
        tab_we = 1'b1; cnt_inc = 1'b1;
        tab_new.tail = f11;
        if (!t_ok) tab_new.head = f11;
        prv_we = 1'b1; prv_wd = t;
        nxt_we = 1'b1;
      end
      K_TAKEH: begin
        tab_we = 1'b1; cnt_dec = 1'b1;
        res_frame_d = h[FRM_W-1:0];
        tab_new.head = n;
        if (n_ok) begin
          prv_we = 1'b1; prv_wa = n[IDX_W-1:0];
        end else begin
          tab_new.tail = NONE_PTR;
        end
      end
      K_TAKET: begin
        tab_we = 1'b1; cnt_dec = 1'b1;
        res_frame_d = t[FRM_W-1:0];
        tab_new.tail = p;
        if (p_ok) begin
          nxt_we = 1'b1; nxt_wa = p[IDX_W-1:0];
        end else begin
          tab_new.head = NONE_PTR;
        end
      end
      K_MID: begin
        tab_we = 1'b1; cnt_dec = 1'b1;
        res_frame_d = req_q.frame;
        if (p_ok) begin
          nxt_we = 1'b1; nxt_wa = p[IDX_W-1:0]; nxt_wd = n;
        end
        if (n_ok) begin
          prv_we = 1'b1; prv_wa = n[IDX_W-1:0]; prv_wd = p;
        end
      end
      K_EMPTY: res_empty_d = 1'b1;
      default: ;
    endcase
    if (cnt_inc)      tab_new.size = cnt_up(tab_cur.size);
    else if (cnt_dec) tab_new.size = cnt_down(tab_cur.size);

    // only the link stores are touched outside the link step
    if (state_q != ST_LNK) begin
      tab_we = 1'b0;
      nxt_we = 1'b0;
      prv_we = 1'b0;
      nxt_wa = t[IDX_W-1:0];
      prv_wa = h[IDX_W-1:0];
      nxt_wd = f11;
      prv_wd = f11;
      if (state_q == ST_W2) begin
        // second write links the old end back to the new frame
        nxt_we = (kind_q == K_ADDT) && t_ok;
        prv_we = (kind_q == K_ADDH) && h_ok;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_TAB;
      ST_TAB:  state_d = ST_LNK;
      ST_LNK:  state_d = ST_W2;
      ST_W2:   if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // list table memory
  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[req_q.list[LIST_W-1:0]] <= tab_new;
    if (q_pop_o && q_req_i.op != OP_NOP_ZERO) tab_rd_q <= tab_mem[q_req_i.list[LIST_W-1:0]];
  end

  // link stores
  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (state_q == ST_TAB) nxt_rd_q <= nxt_mem[nrd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (state_q == ST_TAB) prv_rd_q <= prv_mem[prd_addr];
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) req_q <= q_req_i;
    if (state_q == ST_TAB) kind_q <= kind;
    if (state_q == ST_LNK) begin
      res_frame_q <= res_frame_d;
      res_empty_q <= res_empty_d;
      res_cnt_q   <= (kind_q == K_ZERO) ? '0 : tab_new.size;
    end
    if (state_q == ST_W2 && slot_free) begin
      out_frame_q <= res_frame_q;
      out_empty_q <= res_empty_q;
      out_cnt_q   <= res_cnt_q;
      out_free_q  <= free_q;
      out_zero_q  <= zero_q;
    end
  end

  // control state, table valid bits and aggregate counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tab_vld_q    <= '0;
      tab_rd_vld_q <= 1'b0;
      free_q       <= '0;
      zero_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o && q_req_i.op != OP_NOP_ZERO) begin
        tab_rd_vld_q <= tab_vld_q[q_req_i.list[LIST_W-1:0]];
      end
      if (tab_we) tab_vld_q[req_q.list[LIST_W-1:0]] <= 1'b1;
      if (state_q == ST_LNK) begin
        if (cnt_inc && is_free) free_q <= cnt_up(free_q);
        if (cnt_dec && is_free) free_q <= cnt_down(free_q);
        if (cnt_inc && is_zero) zero_q <= cnt_up(zero_q);
        if (cnt_dec && is_zero) zero_q <= cnt_down(zero_q);
      end
      if (state_q == ST_W2 && slot_free) out_valid_q <= 1'b1;
      else if (out_ready_i)              out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_frame_o  = out_frame_q;
  assign was_empty_o  = out_empty_q;
  assign list_count_o = out_cnt_q;
  assign free_total_o = out_free_q;
  assign zero_total_o = out_zero_q;

endmodule

### hdl/page_frame_list_manager.sv
// Page frame list manager: the back end takes one request at a time through its
// table read, link read, link write and second link write steps, and holds in the
// last step while a previous result still waits for out_ready_i; the result is then
// registered. The two-entry queue lets the front accept while the back end works.
// Reset clears list heads, tails, counts and handshake state at once; the link
// stores are not cleared and need no clearing pass.
`include "page_frame_list_manager_assert.svh"
module page_frame_list_manager import pflm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [SEL_W-1:0] list_sel_i,
  input  logic [FRM_W-1:0] frame_num_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [FRM_W-1:0] out_frame_o,
  output logic             was_empty_o,
  output logic [PTR_W-1:0] list_count_o,
  output logic [PTR_W-1:0] free_total_o,
  output logic [PTR_W-1:0] zero_total_o
);

  logic q_valid, q_pop;
  req_t q_req;

  pflm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .list_sel_i  (list_sel_i),
    .frame_num_i (frame_num_i),
    .q_valid_o   (q_valid),
    .q_req_o     (q_req),
    .q_pop_i     (q_pop)
  );

  pflm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_req_i      (q_req),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_frame_o  (out_frame_o),
    .was_empty_o  (was_empty_o),
    .list_count_o (list_count_o),
    .free_total_o (free_total_o),
    .zero_total_o (zero_total_o)
  );

  // an accepted request is visible to the back end on the next cycle
  `PFLM_ASSERT_NEXT(a_req_queued, in_valid_i && in_ready_o, q_valid)
  // a pop only happens when the queue holds a request
  `PFLM_ASSERT_NOW(a_pop_valid, q_pop, q_valid)
  // an empty pop never reports a frame
  `PFLM_ASSERT_NOW(a_empty_no_frame, out_valid_o && was_empty_o, out_frame_o == '0)
  // free and zeroed totals never pass the number of frames
  `PFLM_ASSERT_NOW(a_cnt_range, out_valid_o, (free_total_o <= NONE_PTR) && (zero_total_o <= NONE_PTR))

endmodule

### test/pflm_checker.sv
// Checker for the page frame list manager: watches both channels, predicts each result
// from its own copy of the lists and compares field by field. Depends on pflm_pkg.
module pflm_checker import pflm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [SEL_W-1:0] list_sel_i,
  input  logic [FRM_W-1:0] frame_num_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [FRM_W-1:0] out_frame_i,
  input  logic             was_empty_i,
  input  logic [PTR_W-1:0] list_count_i,
  input  logic [PTR_W-1:0] free_total_i,
  input  logic [PTR_W-1:0] zero_total_i,
  output int               errors_o,
  output int               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FRM_W-1:0] frame;
    logic             empty;
    logic [PTR_W-1:0] count;
    logic [PTR_W-1:0] free_sum;
    logic [PTR_W-1:0] zero_sum;
  } frame_result_t;

  frame_result_t    awaited_results[$];
  logic [PTR_W-1:0] nxt_link [NUM_FRAMES];
  logic [PTR_W-1:0] prv_link [NUM_FRAMES];
  logic [PTR_W-1:0] head_ptr [NUM_LISTS];
  logic [PTR_W-1:0] tail_ptr [NUM_LISTS];
  logic [PTR_W-1:0] pages    [NUM_LISTS];
  logic [PTR_W-1:0] free_pages;
  logic [PTR_W-1:0] zero_pages;
  int               errors;

  assign errors_o      = errors;
  assign outstanding_o = awaited_results.size();

  function automatic logic [PTR_W-1:0] sat_inc(input logic [PTR_W-1:0] c);
    return (c >= NONE_PTR) ? NONE_PTR : c + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] sat_dec(input logic [PTR_W-1:0] c);
    return (c == '0) ? '0 : c - 1'b1;
  endfunction

  // per-list count plus the free or zeroed aggregate
  task automatic adjust_counts(input int l, input bit up);
    pages[l] = up ? sat_inc(pages[l]) : sat_dec(pages[l]);
    if (l < NUM_BUCKETS) begin
      free_pages = up ? sat_inc(free_pages) : sat_dec(free_pages);
    end else if (l < 2 * NUM_BUCKETS) begin
      zero_pages = up ? sat_inc(zero_pages) : sat_dec(zero_pages);
    end
  endtask

  task automatic unlink_head(input int l, output logic [PTR_W-1:0] f);
    logic [PTR_W-1:0] n;
    f = head_ptr[l];
    n = nxt_link[f[IDX_W-1:0]];
    head_ptr[l] = n;
    if (n < NONE_PTR) prv_link[n[IDX_W-1:0]] = NONE_PTR;
    else tail_ptr[l] = NONE_PTR;
    adjust_counts(l, 1'b0);
  endtask

  task automatic unlink_tail(input int l, output logic [PTR_W-1:0] f);
    logic [PTR_W-1:0] p;
    f = tail_ptr[l];
    p = prv_link[f[IDX_W-1:0]];
    tail_ptr[l] = p;
    if (p < NONE_PTR) nxt_link[p[IDX_W-1:0]] = NONE_PTR;
    else head_ptr[l] = NONE_PTR;
    adjust_counts(l, 1'b0);
  endtask

  // apply one request to the list copy and work out its result
  task automatic apply_list_request(input logic [REQ_W-1:0] req, input logic [SEL_W-1:0] sel,
                                    input logic [FRM_W-1:0] frm, output frame_result_t r);
    int               l;
    logic [PTR_W-1:0] f;
    logic [PTR_W-1:0] h;
    logic [PTR_W-1:0] p;
    logic [PTR_W-1:0] n;
    logic [PTR_W-1:0] taken;
    l     = int'(sel);
    f     = PTR_W'(frm);
    taken = '0;
    r     = '0;
    if (l < NUM_LISTS) begin
      if (req == REQ_ADD_HEAD && f < NONE_PTR) begin
        h = head_ptr[l];
        nxt_link[frm] = h;
        prv_link[frm] = NONE_PTR;
        if (h < NONE_PTR) prv_link[h[IDX_W-1:0]] = f;
        else tail_ptr[l] = f;
        head_ptr[l] = f;
        adjust_counts(l, 1'b1);
      end else if (req == REQ_ADD_TAIL && f < NONE_PTR) begin
        h = tail_ptr[l];
        prv_link[frm] = h;
        nxt_link[frm] = NONE_PTR;
        if (h < NONE_PTR) nxt_link[h[IDX_W-1:0]] = f;
        else head_ptr[l] = f;
        tail_ptr[l] = f;
        adjust_counts(l, 1'b1);
      end else if (req == REQ_POP_HEAD || req == REQ_POP_TAIL ||
                   (req == REQ_REMOVE && f < NONE_PTR)) begin
        if (head_ptr[l] >= NONE_PTR || tail_ptr[l] >= NONE_PTR) begin
          r.empty = 1'b1;
        end else if (req == REQ_POP_HEAD) begin
          unlink_head(l, taken);
        end else if (req == REQ_POP_TAIL || tail_ptr[l] == f) begin
          unlink_tail(l, taken);
        end else if (head_ptr[l] == f) begin
          unlink_head(l, taken);
        end else begin
          // middle frame: bridge its neighbours
          p = prv_link[frm];
          n = nxt_link[frm];
          if (p < NONE_PTR) nxt_link[p[IDX_W-1:0]] = n;
          if (n < NONE_PTR) prv_link[n[IDX_W-1:0]] = p;
          adjust_counts(l, 1'b0);
          taken = f;
        end
      end
      r.count = pages[l];
    end
    r.frame    = taken[FRM_W-1:0];
    r.free_sum = free_pages;
    r.zero_sum = zero_pages;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // monitor: requests in, results out
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t r;
    frame_result_t w;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_ptr[i] = NONE_PTR;
        tail_ptr[i] = NONE_PTR;
        pages[i]    = '0;
      end
      free_pages = '0;
      zero_pages = '0;
      awaited_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          w = awaited_results.pop_front();
          if (out_frame_i !== w.frame) report_mismatch("out_frame", out_frame_i, w.frame);
          if (was_empty_i !== w.empty) report_mismatch("was_empty", was_empty_i, w.empty);
          if (list_count_i !== w.count) report_mismatch("list_count", list_count_i, w.count);
          if (free_total_i !== w.free_sum)
            report_mismatch("free_total", free_total_i, w.free_sum);
          if (zero_total_i !== w.zero_sum)
            report_mismatch("zero_total", zero_total_i, w.zero_sum);
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_list_request(req_type_i, list_sel_i, frame_num_i, r);
        awaited_results.push_back(r);
      end
    end
  end

  initial errors = 0;

endmodule

### test/tb_page_frame_list_manager.sv
// Top of the page frame list manager testbench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on pflm_pkg and pflm_checker.
module tb_page_frame_list_manager;
  import pflm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 2000;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  logic [REQ_W-1:0] req_type;
  logic [SEL_W-1:0] list_sel;
  logic [FRM_W-1:0] frame_num;
  logic             out_valid;
  logic             out_ready;
  logic [FRM_W-1:0] out_frame;
  logic             was_empty;
  logic [PTR_W-1:0] list_count;
  logic [PTR_W-1:0] free_total;
  logic [PTR_W-1:0] zero_total;
  int               errors;
  int               outstanding;

  // stimulus-side view of which frames sit on which list, in order
  int unsigned      members [NUM_LISTS][$];
  bit               placed  [NUM_FRAMES];
  int               placed_total;
  int               sent;

  page_frame_list_manager u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .list_sel_i  (list_sel),
    .frame_num_i (frame_num),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_frame_o (out_frame),
    .was_empty_o (was_empty),
    .list_count_o(list_count),
    .free_total_o(free_total),
    .zero_total_o(zero_total)
  );

  pflm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .req_type_i   (req_type),
    .list_sel_i   (list_sel),
    .frame_num_i  (frame_num),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_frame_i  (out_frame),
    .was_empty_i  (was_empty),
    .list_count_i (list_count),
    .free_total_i (free_total),
    .zero_total_i (zero_total),
    .errors_o     (errors),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // keep the membership view in step with each request
  task automatic track_request(input logic [REQ_W-1:0] req, input int l, input int f);
    if (l < NUM_LISTS) begin
      case (req)
        REQ_ADD_HEAD, REQ_ADD_TAIL: begin
          if (req == REQ_ADD_HEAD) members[l].push_front(f);
          else members[l].push_back(f);
          placed[f] = 1'b1;
          placed_total++;
        end
        REQ_POP_HEAD, REQ_POP_TAIL: begin
          if (members[l].size() > 0) begin
            if (req == REQ_POP_HEAD) placed[members[l].pop_front()] = 1'b0;
            else placed[members[l].pop_back()] = 1'b0;
            placed_total--;
          end
        end
        REQ_REMOVE: begin
          for (int i = 0; i < members[l].size(); i++) begin
            if (members[l][i] == f) begin
              members[l].delete(i);
              placed[f] = 1'b0;
              placed_total--;
              break;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  // offer one request and hold it until accepted
  task automatic send_request(input logic [REQ_W-1:0] req, input int l, input int f,
                              input bit may_idle);
    track_request(req, l, f);
    @(negedge clk_i);
    if (may_idle && $urandom_range(99) < 18) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end
    in_valid  = 1'b1;
    req_type  = req;
    list_sel  = SEL_W'(l);
    frame_num = FRM_W'(f);
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  function automatic int pick_unplaced();
    int f;
    do f = $urandom_range(NUM_FRAMES - 1); while (placed[f]);
    return f;
  endfunction

  // one random request: mostly well-formed list traffic, some noise
  task automatic random_request(input bit may_idle);
    int unsigned roll;
    int          l;
    int          f;
    logic [REQ_W-1:0] req;
    roll = $urandom_range(99);
    l    = $urandom_range(NUM_LISTS - 1);
    f    = 0;
    if (roll < 45 && placed_total < NUM_FRAMES - 64) begin
      req = roll[0] ? REQ_ADD_TAIL : REQ_ADD_HEAD;
      f   = pick_unplaced();
    end else if (roll < 70) begin
      req = roll[0] ? REQ_POP_TAIL : REQ_POP_HEAD;
      f   = $urandom_range(NUM_FRAMES - 1);
    end else if (roll < 90) begin
      req = REQ_REMOVE;
      if (members[l].size() > 0) f = members[l][$urandom_range(members[l].size() - 1)];
      else f = $urandom_range(NUM_FRAMES - 1);
    end else if (roll < 95) begin
      // unknown request code
      req = REQ_W'($urandom_range(7, 5));
      f   = $urandom_range(NUM_FRAMES - 1);
    end else begin
      // list index beyond the last list
      req = REQ_W'($urandom_range(7));
      l   = $urandom_range(63, NUM_LISTS);
      f   = $urandom_range(NUM_FRAMES - 1);
    end
    send_request(req, l, f, may_idle);
  endtask

  // result back-pressure, with one long hold-off
  initial begin
    int cyc;
    cyc       = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= 2000 && cyc < 2400) out_ready = 1'b0;
      else if (cyc >= 5000 && cyc < 6500) out_ready = 1'b1;
      else out_ready = ($urandom_range(99) >= 18);
    end
  end

  initial begin
    in_valid     = 1'b0;
    req_type     = REQ_ADD_HEAD;
    list_sel     = '0;
    frame_num    = '0;
    placed_total = 0;
    sent         = 0;
    rst_ni       = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty pops and removes, extremes, all list kinds, noise codes
    send_request(REQ_POP_HEAD, 0, 0, 1'b0);
    send_request(REQ_POP_TAIL, 33, 1023, 1'b0);
    send_request(REQ_REMOVE, 5, 1023, 1'b0);
    send_request(REQ_ADD_HEAD, 0, 0, 1'b0);
    send_request(REQ_ADD_TAIL, 0, 1023, 1'b0);
    send_request(REQ_ADD_HEAD, 16, 512, 1'b0);
    send_request(REQ_ADD_TAIL, 31, 511, 1'b0);
    send_request(REQ_ADD_TAIL, 33, 341, 1'b0);
    send_request(REQ_ADD_TAIL, 32, 682, 1'b0);
    send_request(REQ_ADD_TAIL, 32, 100, 1'b0);
    send_request(REQ_ADD_TAIL, 32, 200, 1'b0);
    send_request(REQ_ADD_TAIL, 32, 300, 1'b0);
    send_request(REQ_REMOVE, 32, 100, 1'b0);
    send_request(REQ_REMOVE, 32, 682, 1'b0);
    send_request(REQ_REMOVE, 32, 300, 1'b0);
    send_request(REQ_POP_TAIL, 0, 0, 1'b0);
    send_request(REQ_POP_HEAD, 16, 0, 1'b0);
    send_request(REQ_POP_HEAD, 33, 0, 1'b0);
    send_request(REQ_ADD_HEAD, 34, 7, 1'b0);
    send_request(REQ_POP_HEAD, 63, 0, 1'b0);
    send_request(3'd5, 0, 9, 1'b0);
    send_request(3'd7, 31, 1023, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // pause until the block has drained everything
      if (i == 1000) begin
        @(negedge clk_i);
        in_valid = 1'b0;
        while (outstanding != 0) @(posedge clk_i);
      end
      random_request(!(i >= 1200 && i < 1500));
    end
    @(negedge clk_i);
    in_valid = 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/pflm_pkg.sv
hdl/pflm_front.sv
hdl/pflm_back.sv
hdl/page_frame_list_manager.sv
test/pflm_checker.sv
test/tb_page_frame_list_manager.sv
